// File: rtl/core/sis_pkg.sv
`timescale 1ns / 1ps
package sis_pkg;

  localparam int OP_W     = 3;
  localparam int ITEM_W   = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  // set size after reset
  localparam int SET_MAX          = 256;
  // largest set size the register can name
  localparam int SIZE_LIMIT       = (1 << COUNT_W) - 1;
  localparam int UNIVERSE_DEFAULT = 256;
  localparam logic [COUNT_W-1:0] SET_SIZE_RESET = COUNT_W'(SET_MAX);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_POP    = 3'd2,
    OP_FLUSH  = 3'd3,
    OP_FILL   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_ABSENT    = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_RANGE     = 3'd4,
    ST_NOT_EMPTY = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LOOK,
    S_CHECK,
    S_READ,
    S_FILL,
    S_FILL_END
  } state_t;

endpackage

// File: rtl/core/sis_ram.sv
`timescale 1ns / 1ps
module sis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/sparse_integer_set.sv
`timescale 1ns / 1ps
// Sparse integer set: a dense member list and a per-value slot table live in two
// single-port-write RAMs with a registered read. A value is a member when its slot
// entry points below the member count at a list entry that holds the value, so flush
// only clears the count and stale slot entries never need clearing. After reset the
// block stalls its input while it writes zero to every slot entry, min(UNIVERSE, 511)
// entries (256 by default). One request is worked at a time. Flush, unknown operations
// and every check that fails without a memory look-up load their result straight from
// the execute state; pop first reads the last member; add and a remove of an absent
// value make a slot read and then, if the slot entry is live, a list read; a successful
// remove then also reads the last member. A fill of an empty set writes the values 0
// to N-1, N = min(set_size, UNIVERSE), one list and one slot write per cycle. A stalled
// output holds the engine. The next request is accepted as soon as the previous one
// has left the engine, even while its result still waits in the output register.
module sparse_integer_set import sis_pkg::*; #(
  parameter int UNIVERSE = UNIVERSE_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                set_size_we,
  input  logic [COUNT_W-1:0]  set_size,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [ITEM_W-1:0]   item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [ITEM_W-1:0]   popped_item,
  output logic [COUNT_W-1:0]  member_count
);

  // no set can hold more values than the size register can name
  localparam int DEPTH = (UNIVERSE < SIZE_LIMIT) ? UNIVERSE : SIZE_LIMIT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH);

  state_t state, state_next;

  logic [COUNT_W-1:0] size_reg;
  logic [COUNT_W-1:0] count, count_next;
  logic [OP_W-1:0]    req_op;
  logic [ITEM_W-1:0]  req_item;

  logic [COUNT_W-1:0] eff_size;
  logic [COUNT_W-1:0] item_ext;
  logic [COUNT_W-1:0] count_last;
  logic [COUNT_W-1:0] pos_full;
  logic               slot_live;
  logic               slot_hit;
  logic               out_free;

  logic               res_load;
  status_t            res_status;
  logic [ITEM_W-1:0]  res_popped;

  logic               list_we, list_re;
  logic [AW-1:0]      list_waddr, list_raddr;
  logic [COUNT_W-1:0] list_wdata, list_rdata;
  logic               slot_we, slot_re;
  logic [AW-1:0]      slot_waddr, slot_raddr;
  logic [COUNT_W-1:0] slot_wdata, slot_rdata;

  sis_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_list (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .re    (list_re),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  sis_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign eff_size   = (size_reg < DEPTH_C) ? size_reg : DEPTH_C;
  assign item_ext   = COUNT_W'(req_item);
  assign count_last = count - COUNT_W'(1);
  assign pos_full   = slot_rdata - COUNT_W'(1);
  assign slot_live  = (slot_rdata != '0) && (pos_full < count);
  assign slot_hit   = slot_live && (list_rdata == item_ext);
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SET_SIZE_RESET;
    end else if (set_size_we) begin
      size_reg <= set_size;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_op   <= op;
      req_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    res_load     = 1'b0;
    res_status   = ST_OK;
    res_popped   = '0;
    list_we      = 1'b0;
    list_waddr   = count[AW-1:0];
    list_wdata   = item_ext;
    list_re      = 1'b0;
    list_raddr   = count_last[AW-1:0];
    slot_we      = 1'b0;
    slot_waddr   = item_ext[AW-1:0];
    slot_wdata   = count + COUNT_W'(1);
    slot_re      = 1'b0;
    slot_raddr   = item_ext[AW-1:0];

    case (state)
      S_CLEAR: begin
        // sweep the slot table, count doubling as the index
        slot_we    = 1'b1;
        slot_waddr = count[AW-1:0];
        slot_wdata = '0;
        if (count == DEPTH_C - COUNT_W'(1)) begin
          count_next = '0;
          state_next = S_IDLE;
        end else begin
          count_next = count + COUNT_W'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        case (req_op)
          OP_ADD: begin
            if (count < eff_size && item_ext < eff_size) begin
              slot_re    = 1'b1;
              state_next = S_LOOK;
            end else if (out_free) begin
              res_load   = 1'b1;
              res_status = ST_RANGE;
              state_next = S_IDLE;
            end
          end

          OP_REMOVE: begin
            if (count != '0 && item_ext < eff_size) begin
              slot_re    = 1'b1;
              state_next = S_LOOK;
            end else if (out_free) begin
              res_load   = 1'b1;
              state_next = S_IDLE;
              if (count == '0) begin
                res_status = ST_EMPTY;
              end else begin
                res_status = ST_RANGE;
              end
            end
          end

          OP_POP: begin
            if (count != '0) begin
              list_re    = 1'b1;
              state_next = S_READ;
            end else if (out_free) begin
              res_load   = 1'b1;
              res_status = ST_EMPTY;
              state_next = S_IDLE;
            end
          end

          OP_FLUSH: begin
            if (out_free) begin
              res_load   = 1'b1;
              count_next = '0;
              state_next = S_IDLE;
            end
          end

          OP_FILL: begin
            if (count == '0 && eff_size != '0) begin
              state_next = S_FILL;
            end else if (out_free) begin
              res_load   = 1'b1;
              res_status = (count != '0) ? ST_NOT_EMPTY : ST_OK;
              state_next = S_IDLE;
            end
          end

          default: begin
            if (out_free) begin
              res_load   = 1'b1;
              res_status = ST_RANGE;
              state_next = S_IDLE;
            end
          end
        endcase
      end

      S_LOOK: begin
        // fetch the list entry that the slot points at
        list_re    = slot_live;
        list_raddr = pos_full[AW-1:0];
        state_next = S_CHECK;
      end

      S_CHECK: begin
        if (req_op == OP_REMOVE && slot_hit) begin
          list_re    = 1'b1;
          state_next = S_READ;
        end else if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          if (req_op == OP_REMOVE) begin
            res_status = ST_ABSENT;
          end else if (slot_hit) begin
            res_status = ST_PRESENT;
          end else begin
            list_we    = 1'b1;
            slot_we    = 1'b1;
            count_next = count + COUNT_W'(1);
          end
        end
      end

      S_READ: begin
        // hold the read data until the result slot is free
        if (out_free) begin
          res_load   = 1'b1;
          count_next = count_last;
          state_next = S_IDLE;
          if (req_op == OP_REMOVE) begin
            // move the last member into the hole
            list_we    = 1'b1;
            list_waddr = pos_full[AW-1:0];
            list_wdata = list_rdata;
            slot_we    = 1'b1;
            slot_waddr = list_rdata[AW-1:0];
            slot_wdata = slot_rdata;
          end else begin
            res_popped = list_rdata[ITEM_W-1:0];
          end
        end
      end

      S_FILL: begin
        // count doubles as the sweep index
        list_we    = 1'b1;
        list_wdata = count;
        slot_we    = 1'b1;
        slot_waddr = count[AW-1:0];
        count_next = count + COUNT_W'(1);
        if (count == eff_size - COUNT_W'(1)) begin
          state_next = S_FILL_END;
        end
      end

      S_FILL_END: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status       <= res_status;
      popped_item  <= res_popped;
      member_count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("member count beyond store depth");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !list_we && !slot_we)
    else $error("store written while idle");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_EXEC)
    else $error("accepted request not executed");

  a_popped_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> popped_item == '0)
    else $error("popped item set on a failed request");

endmodule
